>>> design/gbdw_pkg.sv
// Shared types and codes for the graph walk core.
package gbdw_pkg;

  localparam int VERTEX_W = 4;
  localparam int VERTEX_N = 16;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_BFS = 2'd1;
  localparam logic [1:0] FUNC_DFS = 2'd2;

  localparam logic [1:0] KIND_VISIT  = 2'd0;
  localparam logic [1:0] KIND_PATH   = 2'd1;
  localparam logic [1:0] KIND_NOPATH = 2'd2;

  localparam logic [2:0] VS_CUR = 3'd0;
  localparam logic [2:0] VS_SRC = 3'd1;
  localparam logic [2:0] VS_DST = 3'd2;
  localparam logic [2:0] VS_TOP = 3'd3;
  localparam logic [2:0] VS_IDX = 3'd4;

  typedef struct packed {
    logic       load;
    logic       add;
    logic       bfs_init;
    logic       dfs_init;
    logic       deq;
    logic       scan_init;
    logic       scan_rev;
    logic       scan_run;
    logic       pop;
    logic       dfs_visit;
    logic       trace_init;
    logic       trace_step;
    logic       path_step;
    logic       out_step;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] vsel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       src_bad;
    logic       cur_is_dst;
    logic       edges_empty;
    logic       q_empty;
    logic       sp_zero;
    logic       scan_done;
    logic       t_is_start;
    logic       n_is_one;
    logic       oidx_last;
    logic       out_free;
  } status_t;

endpackage

>>> design/graph_bfs_dfs_walk_core.sv
// Top level of the directed graph walker: breadth-first shortest path and depth-first walk.
//
//  channel  dir  tdata                               tuser     tlast
//  s_axis   in   [3:0] src_vertex, [7:4] dst_vertex  [1:0] func  -
//  m_axis   out  [3:0] vertex, [4] overflow          [1:0] kind  last
//
// An add-edge item appends its edge if both vertices are in range and the store has room;
// a query scans the stored edges, one read at a time from the single-port edge store, for
// each vertex taken from the queue or stack. One item is worked on at a time.
// Reset empties the edge list and clears all flags; no clearing pass is needed.
// A stalled result holds in the output register; the next item is accepted meanwhile.
module graph_bfs_dfs_walk_core #(
  parameter int NUM_VERTICES = 16,
  parameter int MAX_EDGES    = 64,
  parameter int STACK_DEPTH  = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // src_vertex, dst_vertex
  input  logic [1:0] s_axis_tuser,   // func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // vertex, overflow
  output logic [1:0] m_axis_tuser,   // kind
  output logic       m_axis_tlast
);

  gbdw_pkg::cmd_t    cmd;
  gbdw_pkg::status_t st;
  logic [3:0]        out_vertex;
  logic              out_ovf;

  gbdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gbdw_dpath #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_func_i    (s_axis_tuser),
    .in_src_i     (s_axis_tdata[3:0]),
    .in_dst_i     (s_axis_tdata[7:4]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_vertex_o (out_vertex),
    .out_last_o   (m_axis_tlast),
    .out_ovf_o    (out_ovf)
  );

  assign m_axis_tdata = {3'b000, out_ovf, out_vertex};

endmodule

>>> design/gbdw_ctrl.sv
// Sequencer that steps the datapath through edge adds and graph walks.
module gbdw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gbdw_pkg::status_t st_i,
  output gbdw_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_BADSRC  = 4'd2;
  localparam logic [3:0] S_BPOP    = 4'd3;
  localparam logic [3:0] S_BEMIT   = 4'd4;
  localparam logic [3:0] S_BSCAN   = 4'd5;
  localparam logic [3:0] S_BNOPATH = 4'd6;
  localparam logic [3:0] S_TRACE   = 4'd7;
  localparam logic [3:0] S_BPATH   = 4'd8;
  localparam logic [3:0] S_DPOP    = 4'd9;
  localparam logic [3:0] S_DVISIT  = 4'd10;
  localparam logic [3:0] S_DSCAN   = 4'd11;
  localparam logic [3:0] S_DOUT    = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st_i.func == gbdw_pkg::FUNC_ADD) begin
          cmd_o.add = 1'b1;
          state_d   = S_IDLE;
        end else if (st_i.func != gbdw_pkg::FUNC_BFS && st_i.func != gbdw_pkg::FUNC_DFS) begin
          state_d = S_IDLE;
        end else if (st_i.src_bad) begin
          state_d = S_BADSRC;
        end else if (st_i.func == gbdw_pkg::FUNC_BFS) begin
          cmd_o.bfs_init = 1'b1;
          state_d        = S_BPOP;
        end else begin
          cmd_o.dfs_init = 1'b1;
          state_d        = S_DPOP;
        end
      end
      S_BADSRC: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = gbdw_pkg::KIND_NOPATH;
          cmd_o.vsel = gbdw_pkg::VS_SRC;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_BPOP: begin
        if (st_i.q_empty) begin
          state_d = S_BNOPATH;
        end else begin
          cmd_o.deq = 1'b1;
          state_d   = S_BEMIT;
        end
      end
      S_BEMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = gbdw_pkg::KIND_VISIT;
          cmd_o.vsel = gbdw_pkg::VS_CUR;
          if (st_i.cur_is_dst) begin
            cmd_o.trace_init = 1'b1;
            state_d          = S_TRACE;
          end else if (st_i.edges_empty) begin
            state_d = S_BPOP;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_BSCAN;
          end
        end
      end
      S_BSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_BPOP;
        end
      end
      S_BNOPATH: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = gbdw_pkg::KIND_NOPATH;
          cmd_o.vsel = gbdw_pkg::VS_DST;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_TRACE: begin
        cmd_o.trace_step = 1'b1;
        if (st_i.t_is_start) begin
          state_d = S_BPATH;
        end
      end
      S_BPATH: begin
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.kind      = gbdw_pkg::KIND_PATH;
          cmd_o.vsel      = gbdw_pkg::VS_TOP;
          cmd_o.last      = st_i.n_is_one;
          cmd_o.path_step = 1'b1;
          if (st_i.n_is_one) begin
            state_d = S_IDLE;
          end
        end
      end
      S_DPOP: begin
        if (st_i.sp_zero) begin
          state_d = S_DOUT;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_DVISIT;
        end
      end
      S_DVISIT: begin
        cmd_o.dfs_visit = 1'b1;
        if (st_i.edges_empty) begin
          state_d = S_DPOP;
        end else begin
          cmd_o.scan_init = 1'b1;
          cmd_o.scan_rev  = 1'b1;
          state_d         = S_DSCAN;
        end
      end
      S_DSCAN: begin
        cmd_o.scan_run = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_DPOP;
        end
      end
      S_DOUT: begin
        if (st_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = gbdw_pkg::KIND_VISIT;
          cmd_o.vsel     = gbdw_pkg::VS_IDX;
          cmd_o.last     = st_i.oidx_last;
          cmd_o.out_step = 1'b1;
          if (st_i.oidx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/gbdw_dpath.sv
// Edge store, walk stores, edge scanner and result register of the graph walk core.
module gbdw_dpath #(
  parameter int NUM_VERTICES = 16,
  parameter int MAX_EDGES    = 64,
  parameter int STACK_DEPTH  = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbdw_pkg::cmd_t                cmd_i,
  output gbdw_pkg::status_t             st_o,
  input  logic [1:0]                    in_func_i,
  input  logic [gbdw_pkg::VERTEX_W-1:0] in_src_i,
  input  logic [gbdw_pkg::VERTEX_W-1:0] in_dst_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [gbdw_pkg::VERTEX_W-1:0] out_vertex_o,
  output logic                          out_last_o,
  output logic                          out_ovf_o
);

  localparam int VW   = gbdw_pkg::VERTEX_W;
  localparam int VN   = gbdw_pkg::VERTEX_N;
  localparam int QCAP = (NUM_VERTICES < VN) ? NUM_VERTICES : VN;
  localparam int QIW  = $clog2(QCAP);
  localparam int QCW  = $clog2(QCAP + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int NW   = $clog2(VN + 1);

  logic [VW-1:0] esrc_mem [MAX_EDGES];
  logic [VW-1:0] etgt_mem [MAX_EDGES];
  logic [VW-1:0] stk_mem  [STACK_DEPTH];
  logic [VW-1:0] queue_q  [QCAP];
  logic [VW-1:0] parent_q [VN];
  logic [VW-1:0] rbuf_q   [VN];

  logic [1:0]     func_q;
  logic [VW-1:0]  src_q, dst_q, cur_q, t_q;
  logic [ECW-1:0] ecount_q;
  logic           eovf_q, sovf_q;
  logic [VN-1:0]  visited_q;
  logic [QCW-1:0] head_q, tail_q;
  logic [SPW-1:0] sp_q;
  logic [NW-1:0]  n_q, oidx_q;
  logic [EAW-1:0] idx_q;
  logic           issue_q, pend_q, plast_q, rev_q;
  logic [VW-1:0]  es_rd_q, et_rd_q, stk_rd_q;

  logic [ECW-1:0] ecount_m1;
  logic [EAW-1:0] idx_end;
  logic           add_ok, hit, stk_we;
  logic [SAW-1:0] stk_wa;
  logic [VW-1:0]  stk_wd, vsel_v;
  logic [NW-1:0]  n_m1;

  assign ecount_m1 = ecount_q - ECW'(1);
  assign idx_end   = rev_q ? '0 : ecount_m1[EAW-1:0];
  assign add_ok    = (32'(src_q) < NUM_VERTICES) && (32'(dst_q) < NUM_VERTICES);
  assign hit       = cmd_i.scan_run && pend_q && (es_rd_q == cur_q) && !visited_q[et_rd_q];
  assign n_m1      = n_q - NW'(1);

  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp_q[SAW-1:0];
    stk_wd = et_rd_q;
    if (cmd_i.dfs_init) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = src_q;
    end else if (hit && rev_q && (sp_q < SPW'(STACK_DEPTH))) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && add_ok && (ecount_q < ECW'(MAX_EDGES))) begin
      esrc_mem[ecount_q[EAW-1:0]] <= src_q;
      etgt_mem[ecount_q[EAW-1:0]] <= dst_q;
    end
    if (cmd_i.scan_run && issue_q) begin
      es_rd_q <= esrc_mem[idx_q];
      et_rd_q <= etgt_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stk_mem[sp_q[SAW-1:0] - SAW'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      src_q  <= in_src_i;
      dst_q  <= in_dst_i;
    end
    if (cmd_i.bfs_init) begin
      queue_q[0] <= src_q;
    end
    if (cmd_i.deq) begin
      cur_q <= queue_q[head_q[QIW-1:0]];
    end
    if (cmd_i.dfs_visit) begin
      cur_q <= stk_rd_q;
      if (!visited_q[stk_rd_q]) begin
        rbuf_q[n_q[VW-1:0]] <= stk_rd_q;
      end
    end
    if (hit && !rev_q && (tail_q < QCW'(QCAP))) begin
      parent_q[et_rd_q]          <= cur_q;
      queue_q[tail_q[QIW-1:0]]   <= et_rd_q;
    end
    if (cmd_i.trace_init) begin
      t_q <= dst_q;
    end
    if (cmd_i.trace_step) begin
      rbuf_q[n_q[VW-1:0]] <= t_q;
      if (t_q != src_q) begin
        t_q <= parent_q[t_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q  <= '0;
      eovf_q    <= 1'b0;
      sovf_q    <= 1'b0;
      visited_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      sp_q      <= '0;
      n_q       <= '0;
      oidx_q    <= '0;
      idx_q     <= '0;
      issue_q   <= 1'b0;
      pend_q    <= 1'b0;
      plast_q   <= 1'b0;
      rev_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sovf_q <= 1'b0;
      end
      if (cmd_i.add && add_ok) begin
        if (ecount_q < ECW'(MAX_EDGES)) begin
          ecount_q <= ecount_q + ECW'(1);
        end else begin
          eovf_q <= 1'b1;
        end
      end
      if (cmd_i.bfs_init) begin
        visited_q <= VN'(1) << src_q;
        head_q    <= '0;
        tail_q    <= QCW'(1);
      end
      if (cmd_i.dfs_init) begin
        visited_q <= '0;
        sp_q      <= SPW'(1);
        n_q       <= '0;
        oidx_q    <= '0;
      end
      if (cmd_i.deq) begin
        head_q <= head_q + QCW'(1);
      end
      if (cmd_i.pop) begin
        sp_q <= sp_q - SPW'(1);
      end
      if (cmd_i.dfs_visit && !visited_q[stk_rd_q]) begin
        visited_q[stk_rd_q] <= 1'b1;
        n_q                 <= n_q + NW'(1);
      end
      if (cmd_i.scan_init) begin
        rev_q   <= cmd_i.scan_rev;
        idx_q   <= cmd_i.scan_rev ? ecount_m1[EAW-1:0] : '0;
        issue_q <= 1'b1;
        pend_q  <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        pend_q <= issue_q;
        if (issue_q) begin
          plast_q <= (idx_q == idx_end);
          if (idx_q == idx_end) begin
            issue_q <= 1'b0;
          end
          idx_q <= rev_q ? idx_q - EAW'(1) : idx_q + EAW'(1);
        end
      end
      if (hit) begin
        if (!rev_q) begin
          if (tail_q < QCW'(QCAP)) begin
            visited_q[et_rd_q] <= 1'b1;
            tail_q             <= tail_q + QCW'(1);
          end
        end else if (sp_q < SPW'(STACK_DEPTH)) begin
          sp_q <= sp_q + SPW'(1);
        end else begin
          sovf_q <= 1'b1;
        end
      end
      if (cmd_i.trace_init) begin
        n_q <= '0;
      end
      if (cmd_i.trace_step) begin
        n_q <= n_q + NW'(1);
      end
      if (cmd_i.path_step) begin
        n_q <= n_m1;
      end
      if (cmd_i.out_step) begin
        oidx_q <= oidx_q + NW'(1);
      end
    end
  end

  always_comb begin
    case (cmd_i.vsel)
      gbdw_pkg::VS_CUR: vsel_v = cur_q;
      gbdw_pkg::VS_SRC: vsel_v = src_q;
      gbdw_pkg::VS_DST: vsel_v = dst_q;
      gbdw_pkg::VS_TOP: vsel_v = rbuf_q[n_m1[VW-1:0]];
      gbdw_pkg::VS_IDX: vsel_v = rbuf_q[oidx_q[VW-1:0]];
      default:          vsel_v = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o   <= cmd_i.kind;
      out_vertex_o <= vsel_v;
      out_last_o   <= cmd_i.last;
      out_ovf_o    <= eovf_q | sovf_q;
    end
  end

  assign st_o.func        = func_q;
  assign st_o.src_bad     = !(32'(src_q) < NUM_VERTICES);
  assign st_o.cur_is_dst  = (cur_q == dst_q);
  assign st_o.edges_empty = (ecount_q == '0);
  assign st_o.q_empty     = (head_q == tail_q);
  assign st_o.sp_zero     = (sp_q == '0);
  assign st_o.scan_done   = pend_q && plast_q;
  assign st_o.t_is_start  = (t_q == src_q);
  assign st_o.n_is_one    = (n_q == NW'(1));
  assign st_o.oidx_last   = (oidx_q == n_m1);
  assign st_o.out_free    = !out_valid_o || out_ready_i;

endmodule
